[rtl/core/gukn_pkg.sv]
// Package with shared constants and types for the greedy knapsack block.
`default_nettype none
package gukn_pkg;
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int CAP_W = 24;
    localparam int WT_W = 16;
    localparam int VAL_W = 16;
    localparam int POS_W = 6;
    localparam int STEP_W = $clog2(CAP_W + 1);
    localparam int ENTRY_W = WT_W + VAL_W + POS_W;

    typedef struct packed {
        logic [WT_W-1:0]  item_weight;
        logic [VAL_W-1:0] item_value;
        logic             last_item;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] item_position;
        logic [WT_W-1:0]  out_weight;
        logic [VAL_W-1:0] out_value;
        logic [CAP_W-1:0] copies_taken;
        logic             overflowed;
        logic             last_result;
    } out_item_t;

    typedef struct packed {
        logic [WT_W-1:0]  weight;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] position;
    } entry_t;

    typedef struct packed {
        logic              load_wr;
        logic              overflow_set;
        logic              cap_load;
        logic              rd_en;
        logic              cur_load;
        logic              swap_wr;
        logic              cur_wr;
        logic              div_init;
        logic              div_step;
        logic              emit;
        logic              emit_last;
        logic              clear;
        logic [ADDR_W-1:0] addr;
    } ctrl_cmd_t;
endpackage
`default_nettype wire

[rtl/core/gukn_ram.sv]
// Generic single write port RAM with one registered read port.
`default_nettype none
module gukn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/gukn_ctrl.sv]
// Controller state machine: loading, bubble sort passes, division and result emission.
`default_nettype none
module gukn_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                last_item,
    output      logic                busy,
    output      gukn_pkg::ctrl_cmd_t cmd
);
    import gukn_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SORT = 4'd1;
    localparam logic [3:0] ST_SRD0 = 4'd2;
    localparam logic [3:0] ST_SLD  = 4'd3;
    localparam logic [3:0] ST_SRD  = 4'd4;
    localparam logic [3:0] ST_SCMP = 4'd5;
    localparam logic [3:0] ST_SFIN = 4'd6;
    localparam logic [3:0] ST_GRD  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_EMIT = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pass_reg, pass_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              room;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  idx_inc;

    assign busy    = (state_reg != ST_IDLE);
    assign room    = (count_reg < CNT_W'(MAX_ITEMS));
    assign idx_dec = idx_reg - CNT_W'(1);
    assign idx_inc = idx_reg + CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pass_next  = pass_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.addr   = idx_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                cmd.addr = count_reg[ADDR_W-1:0];
                if (start)
                begin
                    cmd.load_wr      = room;
                    cmd.overflow_set = !room;
                    if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_item)
                    begin
                        cmd.cap_load = 1'b1;
                        pass_next    = '0;
                        state_next   = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                // Each pass bubbles the best remaining entry down to the pass index.
                if (pass_reg + CNT_W'(1) < count_reg)
                begin
                    idx_next   = count_reg - CNT_W'(1);
                    state_next = ST_SRD0;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_GRD;
                end
            end
            ST_SRD0:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SLD;
            end
            ST_SLD:
            begin
                cmd.cur_load = 1'b1;
                state_next   = ST_SRD;
            end
            ST_SRD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.addr   = idx_dec[ADDR_W-1:0];
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                cmd.swap_wr = 1'b1;
                idx_next    = idx_dec;
                if (idx_dec == pass_reg)
                begin
                    state_next = ST_SFIN;
                end
                else
                begin
                    state_next = ST_SRD;
                end
            end
            ST_SFIN:
            begin
                cmd.cur_wr = 1'b1;
                cmd.addr   = pass_reg[ADDR_W-1:0];
                pass_next  = pass_reg + CNT_W'(1);
                state_next = ST_SORT;
            end
            ST_GRD:
            begin
                cmd.rd_en  = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_init = (step_reg == '0);
                cmd.div_step = (step_reg != '0);
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CAP_W))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = (idx_inc == count_reg);
                idx_next      = idx_inc;
                if (idx_inc == count_reg)
                begin
                    cmd.clear  = 1'b1;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_GRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pass_reg  <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pass_reg  <= pass_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end
endmodule
`default_nettype wire

[rtl/core/gukn_dp.sv]
// Datapath: item store, bubble sort compare and swap, restoring divider and result register.
`default_nettype none
module gukn_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gukn_pkg::ctrl_cmd_t  cmd,
    input  wire gukn_pkg::in_item_t   item,
    input  wire logic [23:0]          cfg_data,
    input  wire logic                 cfg_we,
    output      logic                 result_valid,
    output      gukn_pkg::out_item_t  result
);
    import gukn_pkg::*;

    logic [CAP_W-1:0]     cap_reg;
    logic [CAP_W-1:0]     rem_reg;
    logic                 ovf_reg;
    entry_t               cur_reg;
    logic [WT_W-1:0]      best_w_reg;
    logic [VAL_W-1:0]     best_v_reg;
    logic [POS_W-1:0]     best_pos_reg;
    logic [CAP_W-1:0]     q_reg;
    logic [WT_W-1:0]      r_reg;
    logic                 valid_reg;
    out_item_t            result_reg;

    entry_t                  rd_entry;
    entry_t                  wr_entry;
    logic                    ram_we;
    logic [WT_W+VAL_W-1:0]   prod_cur;
    logic [WT_W+VAL_W-1:0]   prod_rd;
    logic                    cur_higher;
    logic [WT_W:0]           trial;
    logic [WT_W:0]           diff;
    logic                    fits;

    gukn_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ITEMS)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.addr),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (cmd.addr),
        .rdata (rd_entry)
    );

    // The carried entry moves down only on a strictly higher ratio, which keeps ties in order.
    assign prod_cur   = cur_reg.value * rd_entry.weight;
    assign prod_rd    = rd_entry.value * cur_reg.weight;
    assign cur_higher = (prod_cur > prod_rd);

    assign ram_we = cmd.load_wr | cmd.swap_wr | cmd.cur_wr;

    always_comb
    begin
        wr_entry = cur_reg;
        if (cmd.load_wr)
        begin
            wr_entry.weight   = item.item_weight;
            wr_entry.value    = item.item_value;
            wr_entry.position = POS_W'(cmd.addr);
        end
        else if (cmd.swap_wr && cur_higher)
        begin
            wr_entry = rd_entry;
        end
    end

    assign trial = {r_reg, q_reg[CAP_W-1]};
    assign fits  = (trial >= {1'b0, best_w_reg});
    assign diff  = trial - {1'b0, best_w_reg};

    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= '0;
            rem_reg   <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.overflow_set)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.cap_load)
            begin
                rem_reg <= cap_reg;
            end
            valid_reg <= cmd.emit;
            if (cmd.emit && (best_w_reg != '0))
            begin
                rem_reg <= CAP_W'(r_reg);
            end
            if (cmd.clear)
            begin
                ovf_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cur_load || (cmd.swap_wr && !cur_higher))
        begin
            cur_reg <= rd_entry;
        end
        if (cmd.div_init)
        begin
            best_w_reg   <= rd_entry.weight;
            best_v_reg   <= rd_entry.value;
            best_pos_reg <= rd_entry.position;
            q_reg        <= rem_reg;
            r_reg        <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg <= {q_reg[CAP_W-2:0], fits};
            r_reg <= fits ? diff[WT_W-1:0] : trial[WT_W-1:0];
        end
        if (cmd.emit)
        begin
            result_reg.item_position <= best_pos_reg;
            result_reg.out_weight    <= best_w_reg;
            result_reg.out_value     <= best_v_reg;
            result_reg.copies_taken  <= (best_w_reg == '0) ? '0 : q_reg;
            result_reg.overflowed    <= ovf_reg;
            result_reg.last_result   <= cmd.emit_last;
        end
    end
endmodule
`default_nettype wire

[rtl/core/greedy_unbounded_knapsack.sv]
// Top level of the greedy unbounded knapsack block.
`default_nettype none
// Usage: items are presented on item with start; an item is taken at a rising
// edge where start is high and busy is low. Loading accepts one item per cycle.
// Each item is stored with its load position; items beyond the store depth are
// dropped and the overflow flag of the set is raised.
// The item marked last_item starts the pass and raises busy. The stored items
// are first put in order of value per weight by a stable bubble sort in the
// store (one read and one write per compare). The sorted list is then walked:
// per item one read, a restoring divider over the remaining capacity and one
// emit; each item is emitted before the next is read, and busy stays high
// throughout the pass. Each result is shown on result for one cycle with
// result_valid high; the receiver cannot stall, so nothing is ever held
// back. busy falls as the final result, marked last_result, is shown, and a
// new set may start at once. The capacity register is written with cfg_we
// and cfg_data; the user must do this only while idle, as the block itself
// does not enforce it.
// Reset clears the capacity, the item count and the overflow flag; the item
// store needs no clearing since only entries of the current set are read.
module greedy_unbounded_knapsack (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output      logic                busy,
    input  wire gukn_pkg::in_item_t  item,
    input  wire logic                cfg_we,
    input  wire logic [23:0]         cfg_data,
    output      logic                result_valid,
    output      gukn_pkg::out_item_t result
);
    import gukn_pkg::*;

    ctrl_cmd_t cmd;

    gukn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (item.last_item),
        .busy      (busy),
        .cmd       (cmd)
    );

    gukn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item         (item),
        .cfg_data     (cfg_data),
        .cfg_we       (cfg_we),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule
`default_nettype wire

[rtl/core/gukn_chk.sv]
// Port-level checker for the greedy knapsack block, bound to the top level.
`default_nettype none
module gukn_chk (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire gukn_pkg::in_item_t  item,
    input wire logic                result_valid,
    input wire gukn_pkg::out_item_t result
);
    import gukn_pkg::*;

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.last_item |=> busy)
        else $error("busy not raised after the last item");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !item.last_item |=> !busy && !result_valid)
        else $error("activity after a plain load");

    a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results in consecutive cycles");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> !busy)
        else $error("still busy at the final result");
endmodule

bind greedy_unbounded_knapsack gukn_chk u_gukn_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire
